FILE: hw/rtl/aabb_pair_collision_response_defines.svh
// Assertion macros used by the checker of the box collision block.
// Depends on a clock named clock and an active-high reset named reset in scope.
`ifndef AABB_PAIR_COLLISION_RESPONSE_DEFINES_SVH
`define AABB_PAIR_COLLISION_RESPONSE_DEFINES_SVH

// Generic clocked assertion, disabled while reset is high.
`define AABB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Implication between an antecedent and a consequent in the following cycle.
`define AABB_NEXT(lbl, ante, cons, msg) \
   `AABB_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

FILE: hw/rtl/aabb_pkg.sv
// Shared types and constants of the box collision block.
// No dependencies; used by the top level, the divider and the checker.
package aabb_pkg;

   localparam int MAX_OBJECTS = 16;
   localparam int IDX_W       = $clog2(MAX_OBJECTS);
   localparam int CNT_W       = $clog2(MAX_OBJECTS + 1);

   localparam int REQ_DATA_W = 304;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 136;

   localparam int DIV_NUM_W = 84;
   localparam int DIV_DEN_W = 49;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

   localparam logic       OP_LOAD     = 1'b0;
   localparam logic       OP_RUN      = 1'b1;
   localparam logic [1:0] KIND_KIN    = 2'd0;
   localparam logic [1:0] KIND_STATIC = 2'd1;

   // Index 0 of each pair is the x axis, index 1 the y axis.
   typedef struct packed {
      logic [1:0]        cancel;
      logic [16:0]       bounce;
      logic [1:0]        kind;
      logic [31:0]       mass;
      logic [1:0][31:0]  vel;
      logic [1:0][30:0]  ext;
      logic [1:0][31:0]  prev;
      logic [1:0][31:0]  pos;
   } obj_rec_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quo;
   } div_rsp_type;

endpackage

FILE: hw/rtl/aabb_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module aabb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: hw/rtl/aabb_div.sv
// Restoring divider, one quotient bit per cycle, rounded to nearest.
// Depends on aabb_pkg.
module aabb_div (
   input  logic                  clock,
   input  logic                  reset,
   input  aabb_pkg::div_req_type req,
   output aabb_pkg::div_rsp_type rsp
);
   import aabb_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_ROUND} state_type;

   state_type              state_ff;
   logic [DIV_NUM_W-1:0]   num_ff;
   logic [DIV_DEN_W-1:0]   den_ff;
   logic [DIV_DEN_W-1:0]   rem_ff;
   logic [DIV_CNT_W-1:0]   cnt_ff;
   logic                   done_ff;
   logic [DIV_NUM_W-1:0]   quo_ff;

   logic [DIV_DEN_W:0]     rem_sh;
   logic                   fits;
   logic                   round_up;

   always_comb begin
      rem_sh   = {rem_ff, num_ff[DIV_NUM_W-1]};
      fits     = rem_sh >= {1'b0, den_ff};
      round_up = {rem_ff, 1'b0} >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req.start) begin
                  num_ff   <= req.num;
                  den_ff   <= req.den;
                  rem_ff   <= '0;
                  cnt_ff   <= DIV_CNT_W'(DIV_NUM_W);
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               // The numerator register shifts out dividend bits and takes in quotient bits.
               rem_ff <= fits ? DIV_DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DIV_DEN_W-1:0];
               num_ff <= {num_ff[DIV_NUM_W-2:0], fits};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == DIV_CNT_W'(1)) begin
                  state_ff <= ST_ROUND;
               end
            end
            ST_ROUND: begin
               quo_ff   <= num_ff + DIV_NUM_W'(round_up);
               done_ff  <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

FILE: hw/rtl/aabb_pair_collision_response.sv
// Box pair collision with restitution; the object table lives in one RAM.
// A load writes one table entry. A run tests each pair, resolving a static contact
// directly and a kinematic contact with two serial divisions, then emits one result
// item per object; the RAM port and the serial divider set the pace of a run.
// Synchronous active-high reset empties the table; entries hold old data until rewritten.
module aabb_pair_collision_response (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // pos_x, pos_y, prev_x, prev_y, width, height, speed_x, speed_y, mass, bounce, pad
   input  logic [aabb_pkg::REQ_DATA_W-1:0]  req_tdata,
   // opcode, kind
   input  logic [aabb_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // object_index, out_pos_x, out_pos_y, out_speed_x, out_speed_y,
   // cancel_force_x, cancel_force_y
   output logic [aabb_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast
);
   import aabb_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RD_A, ST_RD_B, ST_CAP_B, ST_TEST, ST_SMUL, ST_SFIN,
      ST_KMUL, ST_KACC, ST_KDIV, ST_KWAIT, ST_APPLY, ST_WR_A, ST_WR_B,
      ST_NEXT, ST_EM_RD, ST_EM_CAP, ST_EM_OUT
   } state_type;

   typedef enum logic {ACT_A_FIXED, ACT_B_FIXED} act_type;

   state_type             state_ff;
   act_type               act_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      i_ff, j_ff, k_ff;
   obj_rec_type           rec_a_ff, rec_b_ff;
   logic                  ax_ff;
   logic                  dir_ff;
   logic [2:0]            step_ff;
   logic signed [65:0]    prod_ff;
   logic signed [84:0]    acc_ff;
   logic [48:0]           t_ff;
   logic                  neg_ff;
   logic [1:0][31:0]      kv_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_last_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic                  ram_we;
   logic [IDX_W-1:0]      ram_wr_addr, ram_rd_addr;
   obj_rec_type           ram_wr_data, ram_rd_rec, ld_rec;
   logic [$bits(obj_rec_type)-1:0] ram_rd_data;

   logic                  load_go;
   logic                  any_kin, hit, old_x, old_y, ax_c;

   obj_rec_type           sel_a, sel_b, mov, fix;
   logic [31:0]           va, vb, sv, fv;
   logic signed [32:0]    dv;
   logic signed [32:0]    mul_a, mul_b;
   logic signed [84:0]    prod_x;
   logic [32:0]           msum;

   logic [65:0]           p_mag;
   logic [33:0]           q_st;
   logic signed [35:0]    q_sx, fv_x, r_st;
   logic [31:0]           nv_st;

   logic [84:0]           acc_mag;
   logic [DIV_NUM_W-1:0]  q_k;
   logic [31:0]           kin_v;

   div_req_type           div_req;
   div_rsp_type           div_rsp;

   function automatic logic ovl(input logic [31:0] a0, input logic [30:0] asz,
                                input logic [31:0] b0, input logic [30:0] bsz);
      logic signed [33:0] a, b, ae, be;
      a  = {{2{a0[31]}}, a0};
      b  = {{2{b0[31]}}, b0};
      ae = a + {3'b000, asz};
      be = b + {3'b000, bsz};
      return (a < be) && (ae > b);
   endfunction

   aabb_ram #(.WIDTH($bits(obj_rec_type)), .DEPTH(MAX_OBJECTS)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   aabb_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign ram_rd_rec = obj_rec_type'(ram_rd_data);
   assign req_tready = (state_ff == ST_IDLE);
   assign load_go    = req_tvalid && (req_tuser[0] == OP_LOAD) &&
                       (count_ff < CNT_W'(MAX_OBJECTS));

   always_comb begin
      ld_rec         = '0;
      ld_rec.pos[0]  = req_tdata[31:0];
      ld_rec.pos[1]  = req_tdata[63:32];
      ld_rec.prev[0] = req_tdata[95:64];
      ld_rec.prev[1] = req_tdata[127:96];
      ld_rec.ext[0]  = req_tdata[158:128];
      ld_rec.ext[1]  = req_tdata[189:159];
      ld_rec.vel[0]  = req_tdata[221:190];
      ld_rec.vel[1]  = req_tdata[253:222];
      ld_rec.mass    = req_tdata[285:254];
      ld_rec.bounce  = req_tdata[302:286];
      ld_rec.kind    = req_tuser[2:1];
   end

   // RAM port control.
   always_comb begin
      ram_we      = 1'b0;
      ram_wr_addr = i_ff[IDX_W-1:0];
      ram_wr_data = rec_a_ff;
      case (state_ff)
         ST_IDLE: begin
            ram_we      = load_go;
            ram_wr_addr = count_ff[IDX_W-1:0];
            ram_wr_data = ld_rec;
         end
         ST_WR_A: ram_we = 1'b1;
         ST_WR_B: begin
            ram_we      = 1'b1;
            ram_wr_addr = j_ff[IDX_W-1:0];
            ram_wr_data = rec_b_ff;
         end
         default: ram_we = 1'b0;
      endcase
      case (state_ff)
         ST_RD_B:  ram_rd_addr = j_ff[IDX_W-1:0];
         ST_EM_RD: ram_rd_addr = k_ff[IDX_W-1:0];
         default:  ram_rd_addr = i_ff[IDX_W-1:0];
      endcase
   end

   // Contact test on the two fetched records.
   always_comb begin
      any_kin = (rec_a_ff.kind == KIND_KIN) || (rec_b_ff.kind == KIND_KIN);
      hit     = ovl(rec_a_ff.pos[0], rec_a_ff.ext[0], rec_b_ff.pos[0], rec_b_ff.ext[0]) &&
                ovl(rec_a_ff.pos[1], rec_a_ff.ext[1], rec_b_ff.pos[1], rec_b_ff.ext[1]);
      old_x   = ovl(rec_a_ff.prev[0], rec_a_ff.ext[0], rec_b_ff.prev[0], rec_b_ff.ext[0]);
      old_y   = ovl(rec_a_ff.prev[1], rec_a_ff.ext[1], rec_b_ff.prev[1], rec_b_ff.ext[1]);
      // Resolve on y unless only the old y ranges overlapped.
      ax_c    = old_x || !old_y;
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      sel_a = dir_ff ? rec_b_ff : rec_a_ff;
      sel_b = dir_ff ? rec_a_ff : rec_b_ff;
      va    = sel_a.vel[ax_ff];
      vb    = sel_b.vel[ax_ff];
      dv    = $signed({vb[31], vb}) - $signed({va[31], va});
      msum  = {1'b0, sel_a.mass} + {1'b0, sel_b.mass};
      mov   = (act_ff == ACT_A_FIXED) ? rec_b_ff : rec_a_ff;
      fix   = (act_ff == ACT_A_FIXED) ? rec_a_ff : rec_b_ff;
      sv    = mov.vel[ax_ff];
      fv    = fix.vel[ax_ff];
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SMUL: begin
            mul_a = {16'b0, mov.bounce};
            mul_b = {sv[31], sv};
         end
         ST_KMUL: begin
            case (step_ff)
               3'd0: begin
                  mul_a = {1'b0, sel_a.mass};
                  mul_b = {va[31], va};
               end
               3'd1: begin
                  mul_a = {1'b0, sel_b.mass};
                  mul_b = {vb[31], vb};
               end
               3'd2: begin
                  mul_a = {1'b0, sel_b.mass};
                  mul_b = {16'b0, sel_a.bounce};
               end
               3'd3: begin
                  mul_a = {1'b0, t_ff[31:0]};
                  mul_b = dv;
               end
               default: begin
                  mul_a = {16'b0, t_ff[48:32]};
                  mul_b = dv;
               end
            endcase
         end
         default: mul_a = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // Static rebound: -round(e*v) + v_static, ties away from zero, saturated.
   always_comb begin
      p_mag = prod_ff[65] ? 66'(-prod_ff) : 66'(prod_ff);
      q_st  = 34'((p_mag[49:0] + 50'd32768) >> 16);
      q_sx  = {2'b00, q_st};
      fv_x  = {{4{fv[31]}}, fv};
      r_st  = (prod_ff[65] ? q_sx : -q_sx) + fv_x;
      if (r_st > 36'sd2147483647) begin
         nv_st = 32'h7fff_ffff;
      end else if (r_st < -36'sd2147483648) begin
         nv_st = 32'h8000_0000;
      end else begin
         nv_st = r_st[31:0];
      end
   end

   // Kinematic pair: numerator magnitude into the divider, quotient saturated.
   always_comb begin
      prod_x  = {{19{prod_ff[65]}}, prod_ff};
      acc_mag = acc_ff[84] ? 85'(-acc_ff) : 85'(acc_ff);
      div_req.start = (state_ff == ST_KDIV) && (msum != '0);
      div_req.num   = acc_mag[DIV_NUM_W-1:0];
      div_req.den   = {msum, 16'b0};
      q_k = div_rsp.quo;
      if (neg_ff) begin
         kin_v = (q_k > DIV_NUM_W'(64'd2147483648)) ? 32'h8000_0000 : (~q_k[31:0] + 32'd1);
      end else begin
         kin_v = (q_k > DIV_NUM_W'(64'd2147483647)) ? 32'h7fff_ffff : q_k[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  if (req_tuser[0] == OP_LOAD) begin
                     if (load_go) begin
                        count_ff <= count_ff + 1'b1;
                     end
                  end else if (count_ff == CNT_W'(1)) begin
                     k_ff     <= '0;
                     state_ff <= ST_EM_RD;
                  end else if (count_ff != '0) begin
                     i_ff     <= '0;
                     j_ff     <= CNT_W'(1);
                     state_ff <= ST_RD_A;
                  end
               end
            end
            ST_RD_A: state_ff <= ST_RD_B;
            ST_RD_B: begin
               rec_a_ff <= ram_rd_rec;
               state_ff <= ST_CAP_B;
            end
            ST_CAP_B: begin
               rec_b_ff <= ram_rd_rec;
               state_ff <= ST_TEST;
            end
            ST_TEST: begin
               ax_ff <= ax_c;
               if (!any_kin || !hit) begin
                  state_ff <= ST_NEXT;
               end else if (rec_a_ff.kind == KIND_STATIC) begin
                  act_ff   <= ACT_A_FIXED;
                  state_ff <= ST_SMUL;
               end else if (rec_b_ff.kind == KIND_STATIC) begin
                  act_ff   <= ACT_B_FIXED;
                  state_ff <= ST_SMUL;
               end else if (rec_a_ff.kind == KIND_KIN && rec_b_ff.kind == KIND_KIN) begin
                  dir_ff   <= 1'b0;
                  step_ff  <= '0;
                  state_ff <= ST_KMUL;
               end else begin
                  // A trigger in the pair changes nothing.
                  state_ff <= ST_NEXT;
               end
            end
            ST_SMUL: state_ff <= ST_SFIN;
            ST_SFIN: begin
               if (act_ff == ACT_A_FIXED) begin
                  rec_b_ff.vel[ax_ff]    <= nv_st;
                  rec_b_ff.pos[ax_ff]    <= rec_b_ff.prev[ax_ff];
                  rec_b_ff.cancel[ax_ff] <= 1'b1;
               end else begin
                  rec_a_ff.vel[ax_ff]    <= nv_st;
                  rec_a_ff.pos[ax_ff]    <= rec_a_ff.prev[ax_ff];
                  rec_a_ff.cancel[ax_ff] <= 1'b1;
               end
               state_ff <= ST_WR_A;
            end
            ST_KMUL: state_ff <= ST_KACC;
            ST_KACC: begin
               // Numerator: (ma*va + mb*vb) << 16 + (mb*e)*(vb - va).
               case (step_ff)
                  3'd0:    acc_ff <= prod_x <<< 16;
                  3'd1:    acc_ff <= acc_ff + (prod_x <<< 16);
                  3'd2:    t_ff   <= prod_ff[48:0];
                  3'd3:    acc_ff <= acc_ff + prod_x;
                  default: acc_ff <= acc_ff + (prod_x <<< 32);
               endcase
               if (step_ff == 3'd4) begin
                  state_ff <= ST_KDIV;
               end else begin
                  step_ff  <= step_ff + 3'd1;
                  state_ff <= ST_KMUL;
               end
            end
            ST_KDIV: begin
               neg_ff <= acc_ff[84];
               if (msum == '0) begin
                  kv_ff[dir_ff] <= va;
                  if (!dir_ff) begin
                     dir_ff   <= 1'b1;
                     step_ff  <= '0;
                     state_ff <= ST_KMUL;
                  end else begin
                     state_ff <= ST_APPLY;
                  end
               end else begin
                  state_ff <= ST_KWAIT;
               end
            end
            ST_KWAIT: begin
               if (div_rsp.done) begin
                  kv_ff[dir_ff] <= kin_v;
                  if (!dir_ff) begin
                     dir_ff   <= 1'b1;
                     step_ff  <= '0;
                     state_ff <= ST_KMUL;
                  end else begin
                     state_ff <= ST_APPLY;
                  end
               end
            end
            ST_APPLY: begin
               rec_a_ff.vel[ax_ff]    <= kv_ff[0];
               rec_b_ff.vel[ax_ff]    <= kv_ff[1];
               rec_a_ff.pos[ax_ff]    <= rec_a_ff.prev[ax_ff];
               rec_b_ff.pos[ax_ff]    <= rec_b_ff.prev[ax_ff];
               rec_a_ff.cancel[ax_ff] <= 1'b1;
               rec_b_ff.cancel[ax_ff] <= 1'b1;
               state_ff <= ST_WR_A;
            end
            ST_WR_A: state_ff <= ST_WR_B;
            ST_WR_B: state_ff <= ST_NEXT;
            ST_NEXT: begin
               if (j_ff + 1'b1 < count_ff) begin
                  j_ff     <= j_ff + 1'b1;
                  state_ff <= ST_RD_A;
               end else if (i_ff + CNT_W'(2) < count_ff) begin
                  i_ff     <= i_ff + 1'b1;
                  j_ff     <= i_ff + CNT_W'(2);
                  state_ff <= ST_RD_A;
               end else begin
                  k_ff     <= '0;
                  state_ff <= ST_EM_RD;
               end
            end
            ST_EM_RD: state_ff <= ST_EM_CAP;
            ST_EM_CAP: begin
               rsp_data_ff  <= {ram_rd_rec.cancel[1], ram_rd_rec.cancel[0],
                                ram_rd_rec.vel[1], ram_rd_rec.vel[0],
                                ram_rd_rec.pos[1], ram_rd_rec.pos[0], 6'(k_ff)};
               rsp_last_ff  <= (k_ff + 1'b1 == count_ff);
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_EM_OUT;
            end
            ST_EM_OUT: begin
               if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_last_ff) begin
                     count_ff <= '0;
                     state_ff <= ST_IDLE;
                  end else begin
                     k_ff     <= k_ff + 1'b1;
                     state_ff <= ST_EM_RD;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: hw/rtl/aabb_chk.sv
// Port-level checker for the box collision block, bound to its top level.
// Depends on aabb_pkg and the assertion macros header.
`include "aabb_pair_collision_response_defines.svh"

module aabb_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [aabb_pkg::REQ_USER_W-1:0] req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [aabb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);
   import aabb_pkg::*;

   `AABB_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "result item changed while stalled")
   `AABB_ASSERT(a_no_take_while_emit, rsp_tvalid |-> !req_tready, "input taken while a result item is pending")
   `AABB_NEXT(a_last_ends_run, rsp_tvalid && rsp_tready && rsp_tlast, !rsp_tvalid, "result item after the last one of a run")
   `AABB_NEXT(a_load_silent, req_tvalid && req_tready && (req_tuser[0] == OP_LOAD), !rsp_tvalid, "load item produced a result item")

endmodule

bind aabb_pair_collision_response aabb_chk u_chk (.*);
